// File: rtl/fprsc_pkg.sv
// shared types, constants and codes for the framed packet receiver
`default_nettype none

package fprsc_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 4;

    localparam logic [7:0] HEADER_RESET  = 8'hA5;
    localparam logic [7:0] TRAILER_RESET = 8'h5A;
    localparam logic [5:0] MAXLEN_RESET  = 6'd40;

    localparam logic [1:0] REG_HEADER  = 2'd0;
    localparam logic [1:0] REG_TRAILER = 2'd1;
    localparam logic [1:0] REG_MAXLEN  = 2'd2;

    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_ARMED    = 3'd1;
    localparam logic [2:0] EV_STORED   = 3'd2;
    localparam logic [2:0] EV_BYTE_OUT = 3'd3;
    localparam logic [2:0] EV_DROP     = 3'd4;
    localparam logic [2:0] EV_OVERRUN  = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       overrun;
    } t_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } t_result;

    // queued work: one plain result, or a frame of len bytes to emit
    typedef struct packed {
        logic       is_frame;
        logic [2:0] event_res;
        logic [5:0] len;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_EMIT = 2'b10
    } t_back_state;

endpackage

`default_nettype wire

// File: rtl/framed_packet_receiver_sum_check.sv
// top level of the framed packet receiver with additive checksum
//
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      i_in_item    (fprsc_pkg::t_item)
// out       output     o_out_valid / i_out_ready    o_out_result (fprsc_pkg::t_result)
// cfg       input      psel penable pwrite pready   paddr pwdata prdata
//
// one input transaction per cycle while the command queue has room and no frame
// is being emitted; a result passes through the queue and the output register before it leaves
// a closing trailer emits its frame one byte per cycle, while the output is not
// stalled, from the frame store read port, and no input is taken until the
// last byte has been read
// reset is synchronous and needs no clearing pass; stalls on either side hold
// the other side only through the queue, the output register and the frame emission
`default_nettype none

module framed_packet_receiver_sum_check (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire fprsc_pkg::t_item               i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output fprsc_pkg::t_result                  o_out_result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fprsc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [7:0] r_header;
    logic [7:0] r_trailer;
    logic [5:0] r_max_len;
    logic       cfg_wr;

    logic                            q_push;
    fprsc_pkg::t_cmd                 q_in_cmd;
    logic                            q_full;
    logic                            q_pop;
    logic                            q_not_empty;
    fprsc_pkg::t_cmd                 q_out_cmd;
    logic                            ram_we;
    logic [fprsc_pkg::IDX_W-1:0]     ram_waddr;
    logic [7:0]                      ram_wdata;
    logic                            ram_re;
    logic [fprsc_pkg::IDX_W-1:0]     ram_raddr;
    logic [7:0]                      ram_rdata;
    logic                            frame_done;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= fprsc_pkg::HEADER_RESET;
            r_trailer <= fprsc_pkg::TRAILER_RESET;
            r_max_len <= fprsc_pkg::MAXLEN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                fprsc_pkg::REG_HEADER:  r_header  <= pwdata[7:0];
                fprsc_pkg::REG_TRAILER: r_trailer <= pwdata[7:0];
                fprsc_pkg::REG_MAXLEN:  r_max_len <= pwdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            fprsc_pkg::REG_HEADER:  prdata = {24'd0, r_header};
            fprsc_pkg::REG_TRAILER: prdata = {24'd0, r_trailer};
            fprsc_pkg::REG_MAXLEN:  prdata = {26'd0, r_max_len};
            default:                prdata = '0;
        endcase
    end

    fprsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (i_in_item),
        .i_header     (r_header),
        .i_trailer    (r_trailer),
        .i_max_len    (r_max_len),
        .i_q_full     (q_full),
        .i_frame_done (frame_done),
        .o_push       (q_push),
        .o_cmd        (q_in_cmd),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata)
    );

    fprsc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_cmd       (q_in_cmd),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_cmd       (q_out_cmd)
    );

    fprsc_ram #(
        .WIDTH (8),
        .DEPTH (fprsc_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fprsc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_cmd         (q_out_cmd),
        .o_pop         (q_pop),
        .o_re          (ram_re),
        .o_raddr       (ram_raddr),
        .i_rdata       (ram_rdata),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_result      (o_out_result),
        .o_frame_done  (frame_done)
    );

endmodule

`default_nettype wire

// File: rtl/fprsc_ram.sv
// generic single write port ram with registered read
`default_nettype none

module fprsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/fprsc_front.sv
// front end: parser state, checksum, frame store writes and command issue
`default_nettype none

module fprsc_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire fprsc_pkg::t_item           i_item,
    input  wire logic [7:0]                 i_header,
    input  wire logic [7:0]                 i_trailer,
    input  wire logic [5:0]                 i_max_len,
    input  wire logic                       i_q_full,
    input  wire logic                       i_frame_done,
    output logic                            o_push,
    output fprsc_pkg::t_cmd                 o_cmd,
    output logic                            o_we,
    output logic [fprsc_pkg::IDX_W-1:0]     o_waddr,
    output logic [7:0]                      o_wdata
);

    logic       r_armed, n_armed;
    logic [5:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_last, n_last;
    logic       r_busy, n_busy;

    logic       accept;
    logic       close;
    logic [6:0] next_cnt;
    logic [6:0] limit;

    assign o_ready  = !r_busy && !i_q_full;
    assign accept   = i_valid && o_ready;
    assign next_cnt = {1'b0, r_count} + 7'd1;
    assign limit    = (7'(fprsc_pkg::STORE_DEPTH) < {1'b0, i_max_len}) ?
                      7'(fprsc_pkg::STORE_DEPTH) : {1'b0, i_max_len};
    assign close    = r_armed && (i_item.rx_byte == i_trailer) && (r_count != 6'd0)
                      && (r_sum == r_last);
    assign o_waddr  = r_count[fprsc_pkg::IDX_W-1:0];
    assign o_wdata  = i_item.rx_byte;

    always_comb begin
        n_armed = r_armed;
        n_count = r_count;
        n_sum   = r_sum;
        n_last  = r_last;
        n_busy  = r_busy;
        o_push  = 1'b0;
        o_we    = 1'b0;
        o_cmd   = '0;
        if (i_frame_done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            o_push = 1'b1;
            priority if (i_item.overrun) begin
                o_cmd.event_res = fprsc_pkg::EV_OVERRUN;
                n_armed = 1'b0;
                n_count = '0;
                n_sum   = '0;
                n_last  = '0;
            end else if (!r_armed) begin
                if (i_item.rx_byte == i_header) begin
                    o_cmd.event_res = fprsc_pkg::EV_ARMED;
                    n_armed = 1'b1;
                    n_count = '0;
                    n_sum   = '0;
                    n_last  = '0;
                end else begin
                    o_cmd.event_res = fprsc_pkg::EV_IGNORED;
                end
            end else if (close) begin
                o_cmd.is_frame  = 1'b1;
                o_cmd.event_res = fprsc_pkg::EV_BYTE_OUT;
                o_cmd.len       = r_count;
                n_busy  = 1'b1;
                n_armed = 1'b0;
                n_count = '0;
                n_sum   = '0;
                n_last  = '0;
            end else if (next_cnt > limit) begin
                o_cmd.event_res = fprsc_pkg::EV_DROP;
                n_armed = 1'b0;
                n_count = '0;
                n_sum   = '0;
                n_last  = '0;
            end else begin
                o_cmd.event_res = fprsc_pkg::EV_STORED;
                o_we    = 1'b1;
                n_sum   = (r_count != 6'd0) ? r_sum + r_last : r_sum;
                n_last  = i_item.rx_byte;
                n_count = next_cnt[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_count <= '0;
            r_sum   <= '0;
            r_last  <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_armed <= n_armed;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_last  <= n_last;
            r_busy  <= n_busy;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fprsc_queue.sv
// short command queue between front and back
`default_nettype none

module fprsc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire fprsc_pkg::t_cmd  i_cmd,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_not_empty,
    output fprsc_pkg::t_cmd       o_cmd
);

    fprsc_pkg::t_cmd                   r_mem [fprsc_pkg::QUEUE_DEPTH];
    logic [fprsc_pkg::QPTR_W-1:0]      r_wr;
    logic [fprsc_pkg::QPTR_W-1:0]      r_rd;
    logic [fprsc_pkg::QCNT_W-1:0]      r_cnt;
    logic                              do_push;
    logic                              do_pop;

    assign o_full      = (r_cnt == fprsc_pkg::QCNT_W'(fprsc_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + fprsc_pkg::QCNT_W'(do_push) - fprsc_pkg::QCNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

// File: rtl/fprsc_back.sv
// back end: result register and frame emission from the frame store
`default_nettype none

module fprsc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_not_empty,
    input  wire fprsc_pkg::t_cmd            i_cmd,
    output logic                            o_pop,
    output logic                            o_re,
    output logic [fprsc_pkg::IDX_W-1:0]     o_raddr,
    input  wire logic [7:0]                 i_rdata,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output fprsc_pkg::t_result              o_result,
    output logic                            o_frame_done
);

    fprsc_pkg::t_back_state r_state, n_state;
    logic                   r_valid, n_valid;
    fprsc_pkg::t_result     r_out, n_out;
    logic                   r_from_ram, n_from_ram;
    logic [5:0]             r_idx, n_idx;
    logic [5:0]             r_len, n_len;
    logic                   can_load;
    logic [5:0]             rd_idx;

    assign can_load = !r_valid || i_ready;
    assign o_raddr  = rd_idx[fprsc_pkg::IDX_W-1:0];
    assign o_valid  = r_valid;

    always_comb begin
        o_result = r_out;
        if (r_from_ram) begin
            o_result.data_byte = i_rdata;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid && !i_ready;
        n_out        = r_out;
        n_from_ram   = r_from_ram;
        n_idx        = r_idx;
        n_len        = r_len;
        o_pop        = 1'b0;
        o_re         = 1'b0;
        o_frame_done = 1'b0;
        rd_idx       = '0;
        unique case (r_state)
            fprsc_pkg::BK_IDLE: begin
                if (i_q_not_empty && can_load) begin
                    o_pop   = 1'b1;
                    n_valid = 1'b1;
                    n_out   = '0;
                    n_out.event_res = i_cmd.event_res;
                    if (i_cmd.is_frame) begin
                        o_re       = 1'b1;
                        n_from_ram = 1'b1;
                        n_out.last = (i_cmd.len == 6'd1);
                        n_idx      = 6'd1;
                        n_len      = i_cmd.len;
                        if (i_cmd.len == 6'd1) begin
                            o_frame_done = 1'b1;
                        end else begin
                            n_state = fprsc_pkg::BK_EMIT;
                        end
                    end else begin
                        n_from_ram = 1'b0;
                        n_out.last = 1'b1;
                    end
                end
            end
            fprsc_pkg::BK_EMIT: begin
                rd_idx = r_idx;
                if (can_load) begin
                    o_re             = 1'b1;
                    n_valid          = 1'b1;
                    n_out.byte_index = r_idx;
                    n_out.last       = (r_idx == r_len - 6'd1);
                    n_idx            = r_idx + 6'd1;
                    if (r_idx == r_len - 6'd1) begin
                        o_frame_done = 1'b1;
                        n_state      = fprsc_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = fprsc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fprsc_pkg::BK_IDLE;
            r_valid    <= 1'b0;
            r_from_ram <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_from_ram <= n_from_ram;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_idx <= n_idx;
        r_len <= n_len;
    end

endmodule

`default_nettype wire

// File: rtl/fprsc_checker.sv
// port level checks for the framed packet receiver, bound to the top level
`default_nettype none

module fprsc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire fprsc_pkg::t_result             o_out_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_result))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_result.event_res != fprsc_pkg::EV_BYTE_OUT) |->
        o_out_result.last && (o_out_result.data_byte == 8'd0)
        && (o_out_result.byte_index == 6'd0))
        else $error("plain result with frame fields set");

    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_result.last
        && (o_out_result.event_res == fprsc_pkg::EV_BYTE_OUT) |=>
        o_out_valid && (o_out_result.event_res == fprsc_pkg::EV_BYTE_OUT)
        && (o_out_result.byte_index == $past(o_out_result.byte_index) + 6'd1))
        else $error("frame byte run broken");

    a_no_input_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_result.event_res == fprsc_pkg::EV_BYTE_OUT)
        && !o_out_result.last && !i_out_ready |-> !o_in_ready)
        else $error("input taken while a frame is being emitted");

endmodule

bind framed_packet_receiver_sum_check fprsc_checker u_fprsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_result (o_out_result)
);

`default_nettype wire

// File: dv/tb.sv
// testbench for the framed packet receiver: directed plan, random frames, predictor check
`timescale 1ns / 100ps

module tb;

    localparam int QUIET_LIMIT = 3000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 28;

    typedef struct packed {
        logic [7:0] rx;
        logic       ovr;
        logic       typed;
        logic [2:0] ev;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    fprsc_pkg::t_item              i_in_item    = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    fprsc_pkg::t_result            o_out_result;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [fprsc_pkg::PADDR_W-1:0] paddr        = '0;
    logic [31:0]                   pwdata       = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // predictor state and register copies
    logic [7:0]         hdr_cfg    = fprsc_pkg::HEADER_RESET;
    logic [7:0]         trl_cfg    = fprsc_pkg::TRAILER_RESET;
    logic [5:0]         maxlen_cfg = fprsc_pkg::MAXLEN_RESET;
    logic               is_armed   = 1'b0;
    logic [5:0]         fill       = '0;
    logic [7:0]         sum_acc    = '0;
    logic [7:0]         newest     = '0;
    logic [7:0]         frame_mem [fprsc_pkg::STORE_DEPTH];
    fprsc_pkg::t_result pred_res  [fprsc_pkg::STORE_DEPTH];

    fprsc_pkg::t_result pending_results [$];
    fprsc_pkg::t_result got_res;
    fprsc_pkg::t_result exp_res;
    int                 mismatch_cnt = 0;
    int                 live_items   = 0;
    int                 quiet_cycles = 0;

    t_row dir_plan [25] = '{
        '{8'h00, 1'b0, 1'b1, fprsc_pkg::EV_IGNORED},
        '{8'hFF, 1'b1, 1'b1, fprsc_pkg::EV_OVERRUN},
        '{8'h5A, 1'b0, 1'b1, fprsc_pkg::EV_IGNORED},
        '{8'hA5, 1'b0, 1'b1, fprsc_pkg::EV_ARMED},
        '{8'h5A, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'hA5, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'h5A, 1'b0, 1'b0, fprsc_pkg::EV_IGNORED},
        '{8'h00, 1'b1, 1'b1, fprsc_pkg::EV_OVERRUN},
        '{8'hA5, 1'b0, 1'b1, fprsc_pkg::EV_ARMED},
        '{8'h12, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'h12, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'h5A, 1'b0, 1'b0, fprsc_pkg::EV_IGNORED},
        '{8'hA5, 1'b0, 1'b1, fprsc_pkg::EV_ARMED},
        '{8'h00, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'h5A, 1'b0, 1'b0, fprsc_pkg::EV_IGNORED},
        '{8'hA5, 1'b0, 1'b1, fprsc_pkg::EV_ARMED},
        '{8'hFF, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'hFF, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'h5A, 1'b0, 1'b0, fprsc_pkg::EV_IGNORED},
        '{8'hA5, 1'b0, 1'b1, fprsc_pkg::EV_ARMED},
        '{8'h80, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'h80, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'h00, 1'b0, 1'b1, fprsc_pkg::EV_STORED},
        '{8'h5A, 1'b0, 1'b0, fprsc_pkg::EV_IGNORED},
        '{8'h7F, 1'b1, 1'b1, fprsc_pkg::EV_OVERRUN}
    };

    framed_packet_receiver_sum_check dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_result (o_out_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic fprsc_pkg::t_result one_result(input logic [2:0] ev);
        fprsc_pkg::t_result r;
        r.event_res  = ev;
        r.data_byte  = 8'h00;
        r.byte_index = '0;
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic void clear_frame();
        is_armed = 1'b0;
        fill     = '0;
        sum_acc  = 8'h00;
        newest   = 8'h00;
    endfunction

    // returns the number of results the byte causes, left in pred_res
    function automatic int deframe_predict(input fprsc_pkg::t_item it);
        int lim;
        int n;
        if (it.overrun) begin
            clear_frame();
            pred_res[0] = one_result(fprsc_pkg::EV_OVERRUN);
            return 1;
        end
        if (!is_armed) begin
            if (it.rx_byte == hdr_cfg) begin
                clear_frame();
                is_armed    = 1'b1;
                pred_res[0] = one_result(fprsc_pkg::EV_ARMED);
            end else begin
                pred_res[0] = one_result(fprsc_pkg::EV_IGNORED);
            end
            return 1;
        end
        if (it.rx_byte == trl_cfg && fill != 6'd0 && sum_acc == newest) begin
            n = int'(fill);
            for (int k = 0; k < n; k++) begin
                pred_res[k]            = one_result(fprsc_pkg::EV_BYTE_OUT);
                pred_res[k].data_byte  = frame_mem[k];
                pred_res[k].byte_index = 6'(k);
                pred_res[k].last       = (k == n - 1);
            end
            clear_frame();
            return n;
        end
        lim = (int'(maxlen_cfg) < fprsc_pkg::STORE_DEPTH) ? int'(maxlen_cfg)
                                                            : fprsc_pkg::STORE_DEPTH;
        if (int'(fill) + 1 > lim) begin
            clear_frame();
            pred_res[0] = one_result(fprsc_pkg::EV_DROP);
            return 1;
        end
        frame_mem[fill] = it.rx_byte;
        if (fill != 6'd0) begin
            sum_acc = sum_acc + newest;
        end
        newest      = it.rx_byte;
        fill        = fill + 6'd1;
        pred_res[0] = one_result(fprsc_pkg::EV_STORED);
        return 1;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= 100) begin
            $display("tb: mismatch on %s: got %0d, want %0d (%0t)", what, got, want, $time);
        end
    endtask

    // one input transaction; typed rows carry their own single expected result
    task automatic put_item(input fprsc_pkg::t_item it, input bit typed,
                            input logic [2:0] typed_ev);
        int gap;
        int cnt;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(negedge i_clk); while (o_in_ready !== 1'b1);
        cnt = deframe_predict(it);
        if (pred_res[0].event_res != fprsc_pkg::EV_IGNORED) begin
            live_items++;
        end
        if (typed) begin
            pending_results.push_back(one_result(typed_ev));
        end else begin
            for (int k = 0; k < cnt; k++) begin
                pending_results.push_back(pred_res[k]);
            end
        end
        @(posedge i_clk);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic ovr);
        fprsc_pkg::t_item it;
        it.rx_byte = b;
        it.overrun = ovr;
        put_item(it, 1'b0, fprsc_pkg::EV_IGNORED);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (pready !== 1'b1);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fprsc_pkg::REG_HEADER:  hdr_cfg    = val[7:0];
            fprsc_pkg::REG_TRAILER: trl_cfg    = val[7:0];
            fprsc_pkg::REG_MAXLEN:  maxlen_cfg = val[5:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic int pick_len(input int lim);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            n = $urandom_range(1, 6);
        end else if (r < 93) begin
            n = $urandom_range(7, 20);
        end else begin
            n = lim;
        end
        return (n > lim) ? lim : n;
    endfunction

    // header, n bytes ending in the checksum, then the trailer, or cut by an overrun byte
    task automatic send_frame(input int n, input bit bad_sum, input bit cut);
        logic [7:0] acc;
        logic [7:0] b;
        int         cut_at;
        acc    = 8'h00;
        cut_at = cut ? $urandom_range(0, n) : n + 1;
        put_byte(hdr_cfg, 1'b0);
        for (int i = 0; i <= n; i++) begin
            if (i == cut_at) begin
                put_byte(8'($urandom), 1'b1);
                return;
            end
            if (i < n - 1) begin
                b   = 8'($urandom);
                acc = acc + b;
            end else if (i == n - 1) begin
                b = bad_sum ? acc + 8'($urandom_range(1, 255)) : acc;
            end else begin
                b = trl_cfg;
            end
            put_byte(b, 1'b0);
        end
    endtask

    initial begin : stim
        int         goal;
        int         r;
        logic [7:0] new_hdr;
        logic [7:0] new_trl;
        logic [5:0] new_len;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < $size(dir_plan); k++) begin
            put_item('{rx_byte: dir_plan[k].rx, overrun: dir_plan[k].ovr},
                     dir_plan[k].typed, dir_plan[k].ev);
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                case (ph)
                    1: begin
                        new_hdr = 8'h00;
                        new_trl = 8'hFF;
                        new_len = 6'd63;
                    end
                    2: begin
                        new_hdr = 8'hFF;
                        new_trl = 8'h00;
                        new_len = 6'd1;
                    end
                    default: begin
                        new_hdr = 8'($urandom);
                        new_trl = 8'($urandom);
                        new_len = $urandom_range(0, 1) ? 6'($urandom_range(2, 8))
                                                       : 6'($urandom_range(9, 63));
                    end
                endcase
                reg_write(fprsc_pkg::REG_HEADER, {24'd0, new_hdr});
                reg_write(fprsc_pkg::REG_TRAILER, {24'd0, new_trl});
                reg_write(fprsc_pkg::REG_MAXLEN, {26'd0, new_len});
            end
            goal = live_items + PHASE_ITEMS;
            while (live_items < goal) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_frame(pick_len(int'(maxlen_cfg)), 1'b0, 1'b0);
                end else if (r < 78) begin
                    send_frame(pick_len(int'(maxlen_cfg)), 1'b1, 1'b0);
                end else if (r < 84) begin
                    send_frame(pick_len(int'(maxlen_cfg)), 1'b0, 1'b1);
                end else if (r < 90) begin
                    send_frame(int'(maxlen_cfg) + 1, 1'b0, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        put_byte(8'($urandom), $urandom_range(0, 7) == 0);
                    end
                end
                if ($urandom_range(0, 19) == 0) begin
                    drain_results();
                end
            end
        end
        drain_results();
        repeat (80) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin : out_side
        int run;
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // result transaction check, sampled on the falling edge before the accepting edge
    always @(negedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready) begin
            got_res = o_out_result;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, event", int'(got_res.event_res), 0);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res.event_res !== exp_res.event_res) begin
                    flag_mismatch("event_res", int'(got_res.event_res),
                                  int'(exp_res.event_res));
                end
                if (got_res.data_byte !== exp_res.data_byte) begin
                    flag_mismatch("data_byte", int'(got_res.data_byte),
                                  int'(exp_res.data_byte));
                end
                if (got_res.byte_index !== exp_res.byte_index) begin
                    flag_mismatch("byte_index", int'(got_res.byte_index),
                                  int'(exp_res.byte_index));
                end
                if (got_res.last !== exp_res.last) begin
                    flag_mismatch("last", int'(got_res.last), int'(exp_res.last));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

endmodule
